/* hdl/q16_fixed_point_alu_unit_defines.svh */
// assertion helpers used by the checker
`ifndef Q16_FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define Q16_FIXED_POINT_ALU_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define Q16A_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define Q16A_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication that also holds while reset is high
`define Q16A_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/q16a_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package q16a_pkg;

   localparam int MODE_WIDTH = 3;
   localparam int FRAC_WIDTH = 4;

   localparam logic [MODE_WIDTH-1:0] MODE_ADD     = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SUB     = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_MUL     = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_DIV     = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_CONVERT = 3'd4;

   // per-transaction control that rides along the pipeline
   typedef struct packed {
      logic is_div;
      logic q_neg;
      logic sat;
      logic dz;
   } q16a_ctl_type;

endpackage
`default_nettype wire

/* hdl/q16a_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module q16a_front
   import q16a_pkg::*;
#(
   parameter int WORD_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           enable,
   input  wire logic                           in_valid,
   input  wire logic [MODE_WIDTH-1:0]          in_mode,
   input  wire logic signed [WORD_WIDTH-1:0]   in_a,
   input  wire logic signed [WORD_WIDTH-1:0]   in_b,
   input  wire logic [FRAC_WIDTH-1:0]          in_frac,
   input  wire logic [FRAC_WIDTH-1:0]          in_target_frac,
   output logic                                out_valid,
   output q16a_ctl_type                        out_ctl,
   output logic [WORD_WIDTH-1:0]               out_result,
   output logic [WORD_WIDTH+14:0]              out_dividend,
   output logic [WORD_WIDTH-1:0]               out_divisor
);

   localparam int SW = WORD_WIDTH + 1;
   localparam int PW = 2 * WORD_WIDTH + 1;
   localparam int TW = WORD_WIDTH + 16;
   localparam int MW = WORD_WIDTH + 15;

   localparam logic signed [SW-1:0] S_MAX = $signed({2'b00, {(WORD_WIDTH-1){1'b1}}});
   localparam logic signed [SW-1:0] S_MIN = $signed({2'b11, {(WORD_WIDTH-1){1'b0}}});
   localparam logic signed [PW-1:0] P_MAX =
      $signed({{(PW-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}});
   localparam logic signed [PW-1:0] P_MIN =
      $signed({{(PW-WORD_WIDTH+1){1'b1}}, {(WORD_WIDTH-1){1'b0}}});
   localparam logic [WORD_WIDTH-1:0] W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   // stage 1
   logic                           valid1_ff;
   logic [MODE_WIDTH-1:0]          mode1_ff;
   logic [FRAC_WIDTH-1:0]          frac1_ff;
   logic signed [SW-1:0]           addsub1_ff, addsub1_in;
   logic signed [2*WORD_WIDTH-1:0] prod1_ff, prod1_in;
   logic [WORD_WIDTH-1:0]          conv1_ff, conv1_in;
   logic signed [TW-1:0]           t1_ff, t1_in;
   logic signed [WORD_WIDTH-1:0]   b1_ff;

   logic signed [FRAC_WIDTH:0]     shift_dist;
   logic signed [WORD_WIDTH-1:0]   half_w;
   logic signed [TW-1:0]           ash, half_t;

   always_comb begin
      if (in_mode == MODE_SUB) begin
         addsub1_in = SW'(in_a) - SW'(in_b);
      end else begin
         addsub1_in = SW'(in_a) + SW'(in_b);
      end
      prod1_in = (2*WORD_WIDTH)'(in_a) * (2*WORD_WIDTH)'(in_b);

      shift_dist = $signed({1'b0, in_target_frac}) - $signed({1'b0, in_frac});
      if (shift_dist > 0) begin
         conv1_in = in_a << shift_dist[FRAC_WIDTH-1:0];
      end else if (shift_dist < 0) begin
         conv1_in = in_a >>> FRAC_WIDTH'(-shift_dist);
      end else begin
         conv1_in = in_a;
      end

      // scaled dividend with half-divisor rounding toward the quotient sign
      half_w = in_b >>> 1;
      half_t = TW'(half_w);
      ash    = TW'(in_a) <<< in_frac;
      if (in_a[WORD_WIDTH-1] == in_b[WORD_WIDTH-1]) begin
         t1_in = ash + half_t;
      end else begin
         t1_in = ash - half_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
      end
      if (enable) begin
         mode1_ff   <= in_mode;
         frac1_ff   <= in_frac;
         addsub1_ff <= addsub1_in;
         prod1_ff   <= prod1_in;
         conv1_ff   <= conv1_in;
         t1_ff      <= t1_in;
         b1_ff      <= in_b;
      end
   end

   // stage 2
   logic                  valid2_ff;
   q16a_ctl_type          ctl2_ff, ctl2_in;
   logic [WORD_WIDTH-1:0] res2_ff, res2_in;
   logic [MW-1:0]         dvd2_ff, dvd2_in;
   logic [WORD_WIDTH-1:0] dvs2_ff, dvs2_in;

   logic signed [PW-1:0]  prod_ext, rnd, prod_rnd, prod_sh;
   logic signed [TW-1:0]  t_abs;
   logic                  t_neg, b_neg;

   always_comb begin
      prod_ext = PW'(prod1_ff);
      if (frac1_ff != '0) begin
         rnd = PW'(1) <<< (frac1_ff - 1'b1);
      end else begin
         rnd = '0;
      end
      prod_rnd = prod_ext + rnd;
      prod_sh  = prod_rnd >>> frac1_ff;

      t_neg   = t1_ff[TW-1];
      b_neg   = b1_ff[WORD_WIDTH-1];
      t_abs   = t_neg ? -t1_ff : t1_ff;
      dvd2_in = t_abs[MW-1:0];
      dvs2_in = b_neg ? -b1_ff : b1_ff;

      ctl2_in = '0;
      res2_in = '0;
      unique case (mode1_ff) inside
         MODE_ADD, MODE_SUB: begin
            if (addsub1_ff > S_MAX) begin
               res2_in     = W_MAX;
               ctl2_in.sat = 1'b1;
            end else if (addsub1_ff < S_MIN) begin
               res2_in     = W_MIN;
               ctl2_in.sat = 1'b1;
            end else begin
               res2_in = addsub1_ff[WORD_WIDTH-1:0];
            end
         end
         MODE_MUL: begin
            if (prod_sh > P_MAX) begin
               res2_in     = W_MAX;
               ctl2_in.sat = 1'b1;
            end else if (prod_sh < P_MIN) begin
               res2_in     = W_MIN;
               ctl2_in.sat = 1'b1;
            end else begin
               res2_in = prod_sh[WORD_WIDTH-1:0];
            end
         end
         MODE_DIV: begin
            ctl2_in.is_div = 1'b1;
            ctl2_in.q_neg  = t_neg ^ b_neg;
            ctl2_in.dz     = (b1_ff == '0);
         end
         MODE_CONVERT: begin
            res2_in = conv1_ff;
         end
         default: begin
            res2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid2_ff <= valid1_ff;
      end
      if (enable) begin
         ctl2_ff <= ctl2_in;
         res2_ff <= res2_in;
         dvd2_ff <= dvd2_in;
         dvs2_ff <= dvs2_in;
      end
   end

   assign out_valid    = valid2_ff;
   assign out_ctl      = ctl2_ff;
   assign out_result   = res2_ff;
   assign out_dividend = dvd2_ff;
   assign out_divisor  = dvs2_ff;

endmodule
`default_nettype wire

/* hdl/q16a_div_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module q16a_div_step
   import q16a_pkg::*;
#(
   parameter int WORD_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic                   in_valid,
   input  wire q16a_ctl_type           in_ctl,
   input  wire logic [WORD_WIDTH-1:0]  in_result,
   input  wire logic [WORD_WIDTH-1:0]  in_rem,
   input  wire logic [WORD_WIDTH+14:0] in_work,
   input  wire logic [WORD_WIDTH-1:0]  in_divisor,
   output logic                        out_valid,
   output q16a_ctl_type                out_ctl,
   output logic [WORD_WIDTH-1:0]       out_result,
   output logic [WORD_WIDTH-1:0]       out_rem,
   output logic [WORD_WIDTH+14:0]      out_work,
   output logic [WORD_WIDTH-1:0]       out_divisor
);

   localparam int MW = WORD_WIDTH + 15;

   logic                  valid_ff;
   q16a_ctl_type          ctl_ff;
   logic [WORD_WIDTH-1:0] result_ff;
   logic [WORD_WIDTH-1:0] rem_ff, rem_in;
   logic [MW-1:0]         work_ff, work_in;
   logic [WORD_WIDTH-1:0] divisor_ff;

   logic [WORD_WIDTH:0]   shifted, dvs_ext, trial;
   logic                  fits;

   // one restoring step: quotient bits shift in where dividend bits leave
   always_comb begin
      shifted = {in_rem, in_work[MW-1]};
      dvs_ext = {1'b0, in_divisor};
      fits    = (shifted >= dvs_ext);
      trial   = shifted - dvs_ext;
      rem_in  = fits ? trial[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
      work_in = {in_work[MW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         ctl_ff     <= in_ctl;
         result_ff  <= in_result;
         rem_ff     <= rem_in;
         work_ff    <= work_in;
         divisor_ff <= in_divisor;
      end
   end

   assign out_valid   = valid_ff;
   assign out_ctl     = ctl_ff;
   assign out_result  = result_ff;
   assign out_rem     = rem_ff;
   assign out_work    = work_ff;
   assign out_divisor = divisor_ff;

endmodule
`default_nettype wire

/* hdl/q16_fixed_point_alu_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// signed Q-format ALU on WORD_WIDTH-bit words: saturating add and subtract, rounded
// saturating multiply, rounded divide (quotient wraps, zero divisor flagged with a zero
// result) and format conversion; fully pipelined, one transaction accepted every cycle while
// the result side is not stalled; the restoring divider resolves one quotient bit per
// stage over WORD_WIDTH + 15 stages; every operation travels the same path so results
// leave in request order, and a stall on the result side freezes the whole pipeline so
// nothing is dropped or repeated
module q16_fixed_point_alu_unit
   import q16a_pkg::*;
#(
   parameter int WORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [MODE_WIDTH-1:0]         req_mode,
   input  wire logic signed [WORD_WIDTH-1:0]  req_operand_a,
   input  wire logic signed [WORD_WIDTH-1:0]  req_operand_b,
   input  wire logic [FRAC_WIDTH-1:0]         req_frac_bits,
   input  wire logic [FRAC_WIDTH-1:0]         req_target_frac_bits,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [WORD_WIDTH-1:0]       rsp_result,
   output logic                               rsp_saturated,
   output logic                               rsp_divide_by_zero
);

   // dividend magnitude width, also the number of divider stages
   localparam int MW = WORD_WIDTH + 15;

   // global advance: the whole pipeline moves when the output register is free
   logic advance;

   // divider stage boundaries, index 0 is the front-end output
   logic                  valid_s   [0:MW];
   q16a_ctl_type          ctl_s     [0:MW];
   logic [WORD_WIDTH-1:0] result_s  [0:MW];
   logic [WORD_WIDTH-1:0] rem_s     [0:MW];
   logic [MW-1:0]         work_s    [0:MW];
   logic [WORD_WIDTH-1:0] divisor_s [0:MW];

   // output register
   logic                  rsp_valid_ff;
   logic [WORD_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic                  rsp_sat_ff, rsp_sat_in;
   logic                  rsp_dz_ff, rsp_dz_in;

   logic [WORD_WIDTH-1:0] quotient;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // operand prep, multiply, add/sub, conversion and divider setup in two stages
   q16a_front #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .in_valid      (req_valid),
      .in_mode       (req_mode),
      .in_a          (req_operand_a),
      .in_b          (req_operand_b),
      .in_frac       (req_frac_bits),
      .in_target_frac(req_target_frac_bits),
      .out_valid     (valid_s[0]),
      .out_ctl       (ctl_s[0]),
      .out_result    (result_s[0]),
      .out_dividend  (work_s[0]),
      .out_divisor   (divisor_s[0])
   );

   // partial remainder starts empty
   assign rem_s[0] = '0;

   // restoring divider, one quotient bit per stage; non-divide results ride along
   for (genvar i = 0; i < MW; i++) begin : g_div
      q16a_div_step #(
         .WORD_WIDTH(WORD_WIDTH)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .enable     (advance),
         .in_valid   (valid_s[i]),
         .in_ctl     (ctl_s[i]),
         .in_result  (result_s[i]),
         .in_rem     (rem_s[i]),
         .in_work    (work_s[i]),
         .in_divisor (divisor_s[i]),
         .out_valid  (valid_s[i+1]),
         .out_ctl    (ctl_s[i+1]),
         .out_result (result_s[i+1]),
         .out_rem    (rem_s[i+1]),
         .out_work   (work_s[i+1]),
         .out_divisor(divisor_s[i+1])
      );
   end

   // sign fix-up of the quotient and final selection
   always_comb begin
      quotient = work_s[MW][WORD_WIDTH-1:0];
      if (ctl_s[MW].is_div) begin
         if (ctl_s[MW].dz) begin
            // zero divisor returns zero with the flag set
            rsp_result_in = '0;
         end else if (ctl_s[MW].q_neg) begin
            rsp_result_in = -quotient;
         end else begin
            rsp_result_in = quotient;
         end
      end else begin
         rsp_result_in = result_s[MW];
      end
      rsp_sat_in = ctl_s[MW].sat;
      rsp_dz_in  = ctl_s[MW].dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_s[MW];
      end
      if (advance) begin
         rsp_result_ff <= rsp_result_in;
         rsp_sat_ff    <= rsp_sat_in;
         rsp_dz_ff     <= rsp_dz_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_saturated      = rsp_sat_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule
`default_nettype wire

/* hdl/q16a_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "q16_fixed_point_alu_unit_defines.svh"
module q16a_checker #(
   parameter int WORD_WIDTH = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic signed [WORD_WIDTH-1:0] rsp_result,
   input wire logic                         rsp_saturated,
   input wire logic                         rsp_divide_by_zero
);

   // a held result keeps its payload
   `Q16A_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result) && $stable(rsp_saturated) && $stable(rsp_divide_by_zero), "stalled transaction changed")

   // a stalled output blocks intake
   `Q16A_ASSERT_NOW(a_backpressure, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken while output stalled")

   // zero-divisor transactions return zero and never saturate
   `Q16A_ASSERT_NOW(a_dz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_result == '0 && !rsp_saturated, "divide by zero result not clean")

   // nothing comes out right after reset
   `Q16A_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), rsp_valid !== 1'b1, "result valid after reset")

endmodule

bind q16_fixed_point_alu_unit q16a_checker #(.WORD_WIDTH(WORD_WIDTH)) u_checker (.*);
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import q16a_pkg::*;

   localparam int W = 16;

   // mode codes the block does not define, all three must yield zeros
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_5 = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_7 = 3'd7;

   // traffic shaping: sender/receiver idle percentages change by issue count
   localparam int RANDOM_OPS    = 900;
   localparam int PHASE1_START  = 325;
   localparam int PHASE2_START  = 625;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 60;
   localparam int SLOW_PCT      = 87;
   localparam int LIGHT_PCT     = 10;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic signed [W-1:0]   a;
      logic signed [W-1:0]   b;
      logic [FRAC_WIDTH-1:0] frac;
      logic [FRAC_WIDTH-1:0] tfrac;
   } alu_op_type;

   typedef struct packed {
      logic signed [W-1:0] value;
      logic                sat;
      logic                dz;
   } alu_res_type;

   // clock and the one reset at the start
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   // block inputs, all known from time zero
   logic                   req_valid = 1'b0;
   logic [MODE_WIDTH-1:0]  req_mode = '0;
   logic signed [W-1:0]    req_operand_a = '0;
   logic signed [W-1:0]    req_operand_b = '0;
   logic [FRAC_WIDTH-1:0]  req_frac_bits = '0;
   logic [FRAC_WIDTH-1:0]  req_target_frac_bits = '0;
   logic                   rsp_ready = 1'b0;

   logic                   req_ready;
   logic                   rsp_valid;
   logic signed [W-1:0]    rsp_result;
   logic                   rsp_saturated;
   logic                   rsp_divide_by_zero;

   q16_fixed_point_alu_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_operand_a       (req_operand_a),
      .req_operand_b       (req_operand_b),
      .req_frac_bits       (req_frac_bits),
      .req_target_frac_bits(req_target_frac_bits),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result          (rsp_result),
      .rsp_saturated       (rsp_saturated),
      .rsp_divide_by_zero  (rsp_divide_by_zero)
   );

   // operations waiting to be offered, and results the block still owes
   alu_op_type  pending_ops[$];
   alu_res_type owed_results[$];

   int issued = 0;
   int idle_phase = 0;
   int errors = 0;
   int results_seen = 0;
   int mode_count[8];
   int sat_count = 0;
   int dz_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // clamp a full-precision value to the signed word range
   function automatic alu_res_type clamp_word(longint v);
      alu_res_type r;
      longint      wmax;
      longint      wmin;
      r = '0;
      wmax = (longint'(1) <<< (W - 1)) - 1;
      wmin = -wmax - 1;
      if (v > wmax) begin
         r.value = wmax[W-1:0];
         r.sat = 1'b1;
      end else if (v < wmin) begin
         r.value = wmin[W-1:0];
         r.sat = 1'b1;
      end else begin
         r.value = v[W-1:0];
      end
      return r;
   endfunction

   // expected transaction result for one operation
   function automatic alu_res_type alu_expect(alu_op_type op);
      alu_res_type r;
      longint      a;
      longint      b;
      longint      t;
      longint      half;
      longint      quo;
      int          shift_dist;
      r = '0;
      a = longint'($signed(op.a));
      b = longint'($signed(op.b));
      case (op.mode)
         MODE_ADD: r = clamp_word(a + b);
         MODE_SUB: r = clamp_word(a - b);
         MODE_MUL: begin
            t = a * b;
            // round by half an lsb, none when there are no fraction bits
            if (op.frac != 0) t = t + (longint'(1) <<< (op.frac - 1));
            r = clamp_word(t >>> op.frac);
         end
         MODE_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               t = a * (longint'(1) <<< op.frac);
               half = b >>> 1;
               if ((t >= 0) == (b >= 0)) t = t + half;
               else t = t - half;
               // quotient truncates toward zero and wraps, no flag
               quo = t / b;
               r.value = quo[W-1:0];
            end
         end
         MODE_CONVERT: begin
            shift_dist = int'(op.tfrac) - int'(op.frac);
            if (shift_dist > 0) t = a <<< shift_dist;
            else if (shift_dist < 0) t = a >>> (-shift_dist);
            else t = a;
            r.value = t[W-1:0];
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic queue_op(logic [MODE_WIDTH-1:0] mode, logic [W-1:0] a, logic [W-1:0] b,
                           logic [FRAC_WIDTH-1:0] frac, logic [FRAC_WIDTH-1:0] tfrac);
      alu_op_type op;
      op.mode = mode;
      op.a = a;
      op.b = b;
      op.frac = frac;
      op.tfrac = tfrac;
      pending_ops.push_back(op);
   endtask

   // operands lean toward the corners of the word range
   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] v;
      case ($urandom_range(0, 11))
         0: v = 16'h7FFF;
         1: v = 16'h8000;
         2: v = '0;
         3: v = 16'h0001;
         4: v = 16'hFFFF;
         5, 6: v = W'($signed($urandom_range(0, 511)) - 256);
         default: v = W'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_random_op();
      logic [MODE_WIDTH-1:0] mode;
      if ($urandom_range(0, 15) == 0) begin
         mode = MODE_WIDTH'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      end else begin
         mode = MODE_WIDTH'($urandom_range(MODE_ADD, MODE_CONVERT));
      end
      queue_op(mode, pick_operand(), pick_operand(),
               FRAC_WIDTH'($urandom_range(0, 15)), FRAC_WIDTH'($urandom_range(0, 15)));
   endtask

   // driver: offers the next pending operation, holds it until accepted
   always @(posedge clock) begin : driver
      alu_op_type op;
      int         send_idle;
      send_idle = (idle_phase == 0) ? LIGHT_PCT : (idle_phase == 1) ? SLOW_PCT : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            op = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_mode <= op.mode;
            req_operand_a <= op.a;
            req_operand_b <= op.b;
            req_frac_bits <= op.frac;
            req_target_frac_bits <= op.tfrac;
            issued <= issued + 1;
            idle_phase <= (issued + 1 < PHASE1_START) ? 0 :
                          (issued + 1 < PHASE2_START) ? 1 : 2;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random backpressure, plus one long hold-off once the
   // no-idle phase starts so the pipeline fills and stalls its input
   always @(posedge clock) begin : receiver
      int recv_idle;
      recv_idle = (idle_phase == 0) ? SLOW_PCT : (idle_phase == 1) ? LIGHT_PCT : 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_phase == 2 && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   task automatic check_field(string name, logic [W-1:0] want, logic [W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // monitor: predicts on each accepted request, checks each accepted result
   always @(posedge clock) begin : monitor
      alu_op_type  op;
      alu_res_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            op.mode = req_mode;
            op.a = req_operand_a;
            op.b = req_operand_b;
            op.frac = req_frac_bits;
            op.tfrac = req_target_frac_bits;
            owed_results.push_back(alu_expect(op));
            mode_count[op.mode]++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
               errors++;
               $display("%0t ns: result %h with no transaction outstanding",
                        $time, rsp_result);
            end else begin
               want = owed_results.pop_front();
               check_field("result", want.value, rsp_result);
               check_field("saturated", W'(want.sat), W'(rsp_saturated));
               check_field("divide_by_zero", W'(want.dz), W'(rsp_divide_by_zero));
               sat_count += want.sat;
               dz_count += want.dz;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      // add/subtract corners, both clamp directions and the no-clamp edge
      queue_op(MODE_ADD, 16'h7FFF, 16'h7FFF, 4'd0, 4'd0);
      queue_op(MODE_ADD, 16'h8000, 16'h8000, 4'd15, 4'd15);
      queue_op(MODE_ADD, 16'h7FFF, 16'h8000, 4'd8, 4'd3);
      queue_op(MODE_SUB, 16'h8000, 16'h0001, 4'd1, 4'd1);
      queue_op(MODE_SUB, 16'h7FFF, 16'hFFFF, 4'd7, 4'd9);
      queue_op(MODE_SUB, 16'h0000, 16'h8000, 4'd0, 4'd15);
      // multiply: largest product, zero fraction bits, rounding, negative
      queue_op(MODE_MUL, 16'h8000, 16'h8000, 4'd15, 4'd0);
      queue_op(MODE_MUL, 16'h0100, 16'h0200, 4'd0, 4'd0);
      queue_op(MODE_MUL, 16'h0003, 16'h0001, 4'd1, 4'd0);
      queue_op(MODE_MUL, 16'hFFFD, 16'h0001, 4'd1, 4'd0);
      queue_op(MODE_MUL, 16'h7FFF, 16'h8000, 4'd15, 4'd15);
      // divide: zero divisor, wrapping quotient, mixed signs
      queue_op(MODE_DIV, 16'h1234, 16'h0000, 4'd8, 4'd0);
      queue_op(MODE_DIV, 16'h8000, 16'hFFFF, 4'd0, 4'd0);
      queue_op(MODE_DIV, 16'h7FFF, 16'h0001, 4'd15, 4'd15);
      queue_op(MODE_DIV, 16'hFF00, 16'h0300, 4'd8, 4'd0);
      queue_op(MODE_DIV, 16'h0100, 16'hFD00, 4'd8, 4'd0);
      queue_op(MODE_DIV, 16'h8000, 16'h8000, 4'd15, 4'd0);
      // conversion: widest left shift wraps, widest right shift, no shift
      queue_op(MODE_CONVERT, 16'h7FFF, 16'h0000, 4'd0, 4'd15);
      queue_op(MODE_CONVERT, 16'h8000, 16'hFFFF, 4'd15, 4'd0);
      queue_op(MODE_CONVERT, 16'h5A5A, 16'h0000, 4'd9, 4'd9);
      queue_op(MODE_CONVERT, 16'hC001, 16'h0000, 4'd3, 4'd12);
      // undefined modes return all zeros
      queue_op(MODE_SPARE_5, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15);
      queue_op(MODE_SPARE_6, 16'h8000, 16'h7FFF, 4'd1, 4'd14);
      queue_op(MODE_SPARE_7, 16'h7FFF, 16'h0000, 4'd0, 4'd0);
      repeat (RANDOM_OPS) queue_random_op();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all offered, then every owed result back, then a drain period so any stray result is caught
      do @(posedge clock); while (pending_ops.size() != 0 || req_valid);
      do @(posedge clock); while (owed_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results: add %0d, sub %0d, mul %0d, div %0d, convert %0d,",
               results_seen, mode_count[MODE_ADD], mode_count[MODE_SUB],
               mode_count[MODE_MUL], mode_count[MODE_DIV], mode_count[MODE_CONVERT]);
      $display("undefined modes %0d, %0d saturated, %0d zero divisors, %0d errors",
               mode_count[MODE_SPARE_5] + mode_count[MODE_SPARE_6] +
               mode_count[MODE_SPARE_7], sat_count, dz_count, errors);
      if (errors == 0) begin
         $display("** q16_fixed_point_alu_unit: PASSED **");
      end else begin
         $display("** q16_fixed_point_alu_unit: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #400000;
      $display("timeout: %0d results still owed", owed_results.size());
      $display("** q16_fixed_point_alu_unit: FAILED **");
      $finish;
   end

endmodule
